// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/phbt_pkg.sv =====
// ---------------------------------------------------------------------------
// phbt_pkg
// Types and constants of the pipeline hazard and branch timing unit
// ---------------------------------------------------------------------------
package phbt_pkg;

    localparam int STAGES        = 5;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int IDX_LSB       = 4;
    localparam int MAX_RES       = 12;
    localparam int CNT_W         = $clog2(MAX_RES);

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    localparam logic [7:0] NO_REG = 8'hFF;

    // squash replay counter codes
    localparam logic [1:0] SQ_FULL = 2'd2;
    localparam logic [1:0] SQ_ONE  = 2'd1;

    // instruction type codes
    localparam logic [3:0] TYPE_RTYPE    = 4'd1;
    localparam logic [3:0] TYPE_ITYPE    = 4'd2;
    localparam logic [3:0] TYPE_LOAD     = 4'd3;
    localparam logic [3:0] TYPE_STORE    = 4'd4;
    localparam logic [3:0] TYPE_BRANCH   = 4'd5;
    localparam logic [3:0] TYPE_JUMP     = 4'd6;
    localparam logic [3:0] TYPE_JUMP_REG = 4'd8;

    typedef struct packed {
        logic        valid;
        logic        bubble;
        logic [3:0]  kind;
        logic [7:0]  sa;
        logic [7:0]  sb;
        logic [7:0]  dr;
        logic [31:0] pc;
        logic [31:0] tgt;
    } slot_t;

    // input tdata layout, last field in the low bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] target;
        logic [31:0] pc;
        logic [7:0]  dest_reg;
        logic [7:0]  src_b;
        logic [7:0]  src_a;
        logic [3:0]  item_type;
    } in_data_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] cycle_count;
        logic [31:0] retire_pc;
        logic [3:0]  retire_type;
    } out_data_t;

    typedef struct packed {
        logic done_res;
        logic retire_bubble;
        logic retire_valid;
    } out_user_t;

    typedef struct packed {
        logic        rvalid;
        logic        bubble;
        logic        done;
        logic        last;
        logic [3:0]  kind;
        logic [31:0] pc;
        logic [31:0] count;
    } result_t;

    typedef struct packed {
        logic        taken;
        logic [31:0] addr;
    } pred_data_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        pred_data_t       data;
    } pred_wr_t;

    typedef struct packed {
        logic       valid;
        pred_data_t data;
    } pred_entry_t;

    function automatic slot_t bubble_slot();
        slot_t b;
        b        = '0;
        b.valid  = 1'b1;
        b.bubble = 1'b1;
        b.sa     = NO_REG;
        b.sb     = NO_REG;
        b.dr     = NO_REG;
        return b;
    endfunction

endpackage

// ===== design/phbt_pred_table.sv =====
// ---------------------------------------------------------------------------
// phbt_pred_table
// Tagged one-bit branch table: synchronous memory with write forwarding
// ---------------------------------------------------------------------------
module phbt_pred_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [phbt_pkg::IDX_W-1:0]  rd_idx,
    input  phbt_pkg::pred_wr_t          wr,
    output phbt_pkg::pred_entry_t       entry
);
    import phbt_pkg::*;

    pred_data_t             mem [TABLE_ENTRIES];
    pred_data_t             rd_data_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;

    // read-modify-write on the same entry: new data goes straight to the read register
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (wr.en && (wr.idx == rd_idx))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx;
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        entry.valid = valid_reg[rd_idx_reg];
        entry.data  = rd_data_reg;
    end

endmodule

// ===== design/phbt_result_queue.sv =====
// ---------------------------------------------------------------------------
// phbt_result_queue
// Two-entry result queue between the timing engine and the output stream
// ---------------------------------------------------------------------------
module phbt_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  phbt_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output phbt_pkg::result_t out_data
);
    import phbt_pkg::*;

    localparam int DEPTH   = 2;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               pop;

    always_comb
    begin
        space     = (count_reg != COUNT_W'(DEPTH));
        out_valid = (count_reg != '0);
        out_data  = entry_reg[rd_ptr_reg];
        pop       = out_valid && out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + COUNT_W'(1);
                2'b01:   count_reg <= count_reg - COUNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/pipeline_hazard_branch_timing_unit.sv =====
// ---------------------------------------------------------------------------
// pipeline_hazard_branch_timing_unit: five-stage pipeline timing engine
// one simulated cycle per clock while the result queue has space; each result is queued before output
// an item yields 1 to 12 results, set by the stall/squash loop
// async active-low reset empties stages, clears cycle count, table valid bits
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pipeline_hazard_branch_timing_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,   // prediction_enable
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // item_type[3:0], src_a[11:4], src_b[19:12], dest_reg[27:20], pc[59:28],
    // target[91:60], zero pad
    input  logic [phbt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tlast,  // end_of_trace
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // retire_type[3:0], retire_pc[35:4], cycle_count[67:36], zero pad
    output logic [phbt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // retire_valid[0], retire_bubble[1], done_res[2]
    output logic [phbt_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    output logic                                 m_axis_tlast   // last
);
    import phbt_pkg::*;

    slot_t            stage_reg  [STAGES];
    slot_t            stage_next [STAGES];
    slot_t            pair_reg   [2];
    slot_t            pair_next  [2];
    slot_t            held_reg;
    slot_t            held_next;
    slot_t            held_cur;
    slot_t            in_slot;
    logic [1:0]       sq_cnt_reg;
    logic [1:0]       sq_cnt_next;
    logic [31:0]      cycles_reg;
    logic [31:0]      cycles_next;
    logic             pe_reg;
    logic             active_reg;
    logic             end_reg;
    logic [CNT_W-1:0] cnt_reg;

    in_data_t         in_d;
    logic             starting;
    logic             step;
    logic             cur_end;
    logic [CNT_W-1:0] cur_cnt;
    logic             done_now;
    logic             lu;
    logic             use_ab;
    logic             use_a;
    logic             hold;
    logic             fin;
    logic             squash;
    logic             is_jump;
    logic             is_branch;
    logic             taken;
    logic             hit;
    logic             wr_req;
    logic [31:0]      bpc;
    logic [31:0]      rd_pc;

    pred_wr_t         pred_wr;
    pred_entry_t      pred_entry;
    result_t          res;
    result_t          head;
    logic             q_space;
    out_data_t        out_d;
    out_user_t        out_u;

    phbt_pred_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_pc[IDX_LSB +: IDX_W]),
        .wr     (pred_wr),
        .entry  (pred_entry)
    );

    phbt_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (res),
        .space     (q_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    // item control
    always_comb
    begin
        in_d              = in_data_t'(s_axis_tdata);
        in_slot           = '0;
        in_slot.valid     = 1'b1;
        in_slot.kind      = in_d.item_type;
        in_slot.sa        = in_d.src_a;
        in_slot.sb        = in_d.src_b;
        in_slot.dr        = in_d.dest_reg;
        in_slot.pc        = in_d.pc;
        in_slot.tgt       = in_d.target;

        s_axis_tready = !active_reg && q_space;
        starting      = s_axis_tvalid && s_axis_tready;
        step          = active_reg ? q_space : starting;
        cur_end       = active_reg ? end_reg : s_axis_tlast;
        cur_cnt       = active_reg ? cnt_reg : '0;
        held_cur      = cur_end ? slot_t'('0) : (starting ? in_slot : held_reg);
        done_now      = cur_end && !stage_reg[STAGES-1].valid;
    end

    // load followed by a dependent user
    always_comb
    begin
        use_ab = (stage_reg[0].kind == TYPE_RTYPE) || (stage_reg[0].kind == TYPE_STORE) ||
                 (stage_reg[0].kind == TYPE_BRANCH);
        use_a  = (stage_reg[0].kind == TYPE_ITYPE) || (stage_reg[0].kind == TYPE_LOAD) ||
                 (stage_reg[0].kind == TYPE_JUMP_REG);
        lu     = stage_reg[1].valid && stage_reg[0].valid &&
                 (stage_reg[1].kind == TYPE_LOAD) &&
                 ((use_ab && ((stage_reg[1].dr == stage_reg[0].sa) ||
                              (stage_reg[1].dr == stage_reg[0].sb))) ||
                  (use_a && (stage_reg[1].dr == stage_reg[0].sa)));
    end

    // one simulated cycle
    always_comb
    begin
        stage_next  = stage_reg;
        pair_next   = pair_reg;
        sq_cnt_next = sq_cnt_reg;
        held_next   = held_cur;
        cycles_next = cycles_reg;
        hold        = 1'b0;
        squash      = 1'b0;
        wr_req      = 1'b0;
        is_jump     = 1'b0;
        is_branch   = 1'b0;
        hit         = 1'b0;
        taken       = 1'b0;
        bpc         = stage_reg[1].pc;

        if (!done_now)
        begin
            for (int i = STAGES - 1; i > 0; i--)
            begin
                stage_next[i] = stage_reg[i-1];
            end
            if (lu)
            begin
                stage_next[1] = bubble_slot();
                stage_next[0] = stage_reg[0];
                hold          = 1'b1;
            end
            else if (sq_cnt_reg != 2'd0)
            begin
                // replay the squashed slots, older one first
                held_next     = (sq_cnt_reg == SQ_FULL) ? pair_reg[1] : pair_reg[0];
                hold          = (sq_cnt_reg == SQ_FULL);
                stage_next[0] = held_next;
                sq_cnt_next   = sq_cnt_reg - SQ_ONE;
            end
            else
            begin
                stage_next[0] = held_cur;
            end

            // stage 2 after the shift is the old stage 1, whose table entry is in pred_entry
            is_jump   = stage_next[2].valid && ((stage_next[2].kind == TYPE_JUMP) ||
                                                (stage_next[2].kind == TYPE_JUMP_REG));
            is_branch = stage_next[1].valid && stage_next[2].valid &&
                        (stage_next[2].kind == TYPE_BRANCH);
            taken     = (stage_next[2].tgt == stage_next[1].pc);
            hit       = pred_entry.valid && (pred_entry.data.addr == bpc);

            if (is_jump)
            begin
                squash = 1'b1;
            end
            else if (is_branch)
            begin
                if (!pe_reg)
                begin
                    squash = taken;
                end
                else if (!hit)
                begin
                    wr_req = 1'b1;
                    squash = taken;
                end
                else if (pred_entry.data.taken != taken)
                begin
                    wr_req = 1'b1;
                    squash = 1'b1;
                end
            end

            if (squash)
            begin
                pair_next[0]  = stage_next[0];
                pair_next[1]  = stage_next[1];
                stage_next[1] = bubble_slot();
                stage_next[0] = bubble_slot();
                sq_cnt_next   = SQ_FULL;
                hold          = 1'b1;
            end

            cycles_next = cycles_reg + 32'd1;
        end

        pred_wr.en         = step && wr_req;
        pred_wr.idx        = bpc[IDX_LSB +: IDX_W];
        pred_wr.data.taken = taken;
        pred_wr.data.addr  = bpc;

        // table read address follows the slot that lands in stage 1
        rd_pc = step ? stage_next[1].pc : stage_reg[1].pc;

        fin = done_now || (cur_cnt == CNT_W'(MAX_RES - 1)) || (!cur_end && !hold);

        res        = '0;
        res.rvalid = !done_now && stage_next[STAGES-1].valid;
        res.bubble = res.rvalid && stage_next[STAGES-1].bubble;
        res.kind   = res.rvalid ? stage_next[STAGES-1].kind : 4'd0;
        res.pc     = res.rvalid ? stage_next[STAGES-1].pc : 32'd0;
        res.count  = cycles_next;
        res.done   = done_now;
        res.last   = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                stage_reg[i] <= '0;
            end
            sq_cnt_reg <= '0;
            cycles_reg <= '0;
            pe_reg     <= 1'b0;
            active_reg <= 1'b0;
            end_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pe_reg <= cfg_wr_data;
            end
            if (step)
            begin
                stage_reg  <= stage_next;
                sq_cnt_reg <= sq_cnt_next;
                cycles_reg <= cycles_next;
                active_reg <= !fin;
                end_reg    <= cur_end;
                cnt_reg    <= cur_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg  <= held_next;
            pair_reg  <= pair_next;
        end
    end

    always_comb
    begin
        out_d.pad           = '0;
        out_d.cycle_count   = head.count;
        out_d.retire_pc     = head.pc;
        out_d.retire_type   = head.kind;
        out_u.done_res      = head.done;
        out_u.retire_bubble = head.bubble;
        out_u.retire_valid  = head.rvalid;
        m_axis_tdata        = out_d;
        m_axis_tuser        = out_u;
        m_axis_tlast        = head.last;
    end

    `ASSERT_IMPLY(a_done_form, clk, rst_n, m_axis_tvalid && head.done, head.last && !head.rvalid)
    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, !active_reg || (cnt_reg < CNT_W'(MAX_RES)))
    `ASSERT_NEXT(a_fin_idle, clk, rst_n, step && fin, !active_reg)
    `ASSERT_ALWAYS(a_sq_range, clk, rst_n, sq_cnt_reg != 2'd3)

endmodule
